### sv/ksf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksf_pkg: shared definitions of the kernel smoothing filter
// Sizes, payload structs, item codes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ksf_pkg;

    localparam int MAX_TAPS    = 63;
    localparam int SAMPLE_BITS = 24;
    localparam int WEIGHT_BITS = 16;

    // Field widths fixed by the item formats.
    localparam int KIND_BITS      = 1;
    localparam int COEF_IDX_BITS  = 6;
    localparam int HALF_CFG_BITS  = 5;
    localparam int POS_BITS       = 7;
    localparam int POS_MAX        = 127;
    localparam logic [HALF_CFG_BITS-1:0] HALF_RESET = HALF_CFG_BITS'(17);

    // Derived sizes.
    localparam int HALF_LIM = (MAX_TAPS - 1) / 2;
    localparam int HALF_W   = $clog2(HALF_LIM + 1);
    localparam int ADDR_W   = $clog2(MAX_TAPS);
    localparam int FILL_W   = $clog2(MAX_TAPS + 1);
    localparam int PROD_W   = SAMPLE_BITS + WEIGHT_BITS + 1;
    localparam int ACC_W    = PROD_W + $clog2(MAX_TAPS);

    // Item kinds.
    localparam logic [KIND_BITS-1:0] KIND_SAMPLE = 1'b0;
    localparam logic [KIND_BITS-1:0] KIND_COEF   = 1'b1;

    typedef struct packed {
        logic [KIND_BITS-1:0]         kind;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          row_end;
        logic [COEF_IDX_BITS-1:0]      coef_index;
        logic [WEIGHT_BITS-1:0]        coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smoothed;
        logic                          last_of_row;
        logic                          saturated;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MAC,
        ST_DRAIN,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic accept;    // input transfer this cycle
        logic setup;     // prepare counters and clear the accumulator
        logic issue;     // read one tap pair into the MAC pipeline
        logic load_out;  // move the rounded sum into the output register
    } cmd_t;

    typedef struct packed {
        logic is_sample;  // incoming item is a data sample
        logic emit;       // incoming sample completes at least one output
        logic last_tap;   // tap counter sits on the final tap
        logic drain_done; // no read is waiting in the first pipeline stage
        logic pipe_empty; // whole MAC pipeline is empty
        logic out_free;   // output register can take a result this cycle
        logic last_out;   // the output being finished is the last of the item
    } status_t;

endpackage

### sv/kernel_smoothing_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_smoothing_filter_core: centred FIR smoothing of histogram rows
// Kernel of 2*H+1 independently loadable taps, zero padding at both row ends,
// rounded and saturated Q12.12 results with a clipping flag.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload       Moves
//  -------  -------------------  ------------  --------------------------------
//  in       in_valid / in_stall  in_item_t     samples and coefficient writes
//  out      out_valid/out_stall  out_item_t    smoothed bins, one per transfer
//  cfg      cfg_valid/cfg_ready  5-bit value   half width register write
//
// An input item that causes no result is taken while the controller stays
// idle. Each result runs one setup step, 2*H+1 tap steps (H the effective
// half width) on the single shared multiply-accumulate unit, whose tap
// rate is set by the one read port of each RAM, the drain and one delivery
// step. A sample that marks the row end yields up to H+1 results in a row.
// Reset is asynchronous and active low; it clears the counters, sets the half
// width to 17 and needs no clearing pass, because a fill count masks window
// entries that hold no sample of the current row. The kernel RAM is not reset.
// A stalled output holds the finished result in the output register, and the
// next result waits in the delivery step; input is taken again once the last
// result of the item sits in the output register.
// ----------------------------------------------------------------------------
module kernel_smoothing_filter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ksf_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ksf_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ksf_pkg::HALF_CFG_BITS-1:0] cfg_data
);

    import ksf_pkg::*;

    cmd_t    cmd;
    status_t st;

    // The half width register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // The controller decides when items are taken and when each output is
    // started, looped over its taps, drained and delivered.
    ksf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath owns all storage and arithmetic.
    ksf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .st        (st),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // A result is only loaded when the output register is empty or leaving.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || !out_stall))
        else $error("result loaded over a pending output transfer");

    // No input is taken while the tap loop is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> !cmd.accept)
        else $error("input accepted during the tap loop");

    // A new output starts only with an empty MAC pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.setup |-> st.pipe_empty)
        else $error("output setup with products still in flight");
`endif

endmodule

### sv/ksf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents have no reset.
// ----------------------------------------------------------------------------
module ksf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/ksf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksf_ctrl: sequencing state machine of the smoothing filter
// Accepts items, then for each output runs setup, the tap loop, the pipeline
// drain and the delivery into the output register.
// ----------------------------------------------------------------------------
module ksf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ksf_pkg::status_t st,
    output ksf_pkg::cmd_t    cmd
);

    import ksf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && st.is_sample && st.emit)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (st.last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (st.drain_done)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (st.out_free)
                begin
                    state_next = st.last_out ? ST_IDLE : ST_SETUP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            ST_MAC:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_DELIVER:
            begin
                cmd.load_out = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### sv/ksf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksf_datapath: storage and multiply-accumulate of the smoothing filter
// Holds the circular sample window, the kernel RAM, the row counters, the
// shared MAC pipeline, rounding with saturation and the output register.
// ----------------------------------------------------------------------------
module ksf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ksf_pkg::cmd_t                       cmd,
    input  ksf_pkg::in_item_t                   in_data,
    input  logic                                cfg_valid,
    input  logic [ksf_pkg::HALF_CFG_BITS-1:0]   cfg_data,
    input  logic                                out_stall,
    output ksf_pkg::status_t                    st,
    output logic                                out_valid,
    output ksf_pkg::out_item_t                  out_data
);

    import ksf_pkg::*;

    localparam int R_W = ACC_W + 1 - WEIGHT_BITS;
    localparam logic [ACC_W:0] ROUND_K = (ACC_W + 1)'(1) << (WEIGHT_BITS - 1);

    // Control registers.
    logic [HALF_CFG_BITS-1:0] half_width_reg;
    logic [ADDR_W-1:0]        wp_reg;
    logic [POS_BITS-1:0]      pos_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic [HALF_W-1:0]        c_reg;
    logic                     row_mode_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     out_valid_reg;

    // Loop counters and payload registers.
    logic [ADDR_W-1:0]        t_reg;
    logic signed [ADDR_W+1:0] d_reg;
    logic [ADDR_W-1:0]        raddr_reg;
    logic                     tag1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    out_item_t                out_data_reg;

    logic [HALF_W-1:0]        h;
    logic [ADDR_W-1:0]        wp_next;
    logic [POS_BITS-1:0]      pos_next;
    logic [FILL_W-1:0]        fill_next;
    logic [HALF_W-1:0]        c_next;
    logic [ADDR_W:0]          ch;
    logic [ADDR_W:0]          start_x;
    logic [ADDR_W-1:0]        raddr_next;
    logic                     d_ok;
    logic                     win_we;
    logic                     coef_we;
    logic signed [SAMPLE_BITS-1:0] win_q;
    logic [WEIGHT_BITS-1:0]   w_q;
    logic signed [PROD_W-1:0] mult;
    logic [ACC_W:0]           rsum;
    logic [R_W-1:0]           rnd;
    logic                     sat;
    logic [SAMPLE_BITS-1:0]   clamped;
    out_item_t                out_data_next;

    // Effective half width, limited to what the window can hold.
    assign h = (int'(half_width_reg) > HALF_LIM) ? HALF_W'(HALF_LIM) : HALF_W'(half_width_reg);

    assign wp_next   = (wp_reg == ADDR_W'(MAX_TAPS - 1)) ? '0 : wp_reg + ADDR_W'(1);
    assign pos_next  = (int'(pos_reg) == POS_MAX) ? pos_reg : pos_reg + POS_BITS'(1);
    assign fill_next = (int'(fill_reg) == MAX_TAPS) ? fill_reg : fill_reg + FILL_W'(1);
    assign c_next    = (int'(pos_next) > int'(h)) ? h : HALF_W'(pos_next - POS_BITS'(1));

    // Oldest window entry of the first tap lies c + h samples before the newest.
    assign ch      = (ADDR_W + 1)'(c_reg) + (ADDR_W + 1)'(h);
    assign start_x = ({1'b0, wp_reg} >= ch) ? ({1'b0, wp_reg} - ch)
                   : ({1'b0, wp_reg} + (ADDR_W + 1)'(MAX_TAPS) - ch);
    assign raddr_next = (raddr_reg == ADDR_W'(MAX_TAPS - 1)) ? '0 : raddr_reg + ADDR_W'(1);

    // Entries at or beyond the fill count belong to no sample of this row.
    assign d_ok = !d_reg[ADDR_W+1] && (d_reg[ADDR_W:0] < (ADDR_W + 1)'(fill_reg));

    assign win_we  = cmd.accept && (in_data.kind == KIND_SAMPLE);
    assign coef_we = cmd.accept && (in_data.kind == KIND_COEF)
                  && (int'(in_data.coef_index) < MAX_TAPS);

    ksf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_window_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (wp_next),
        .wdata (in_data.sample),
        .raddr (raddr_reg),
        .rdata (win_q)
    );

    ksf_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_TAPS)
    ) u_kernel_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (ADDR_W'(in_data.coef_index)),
        .wdata (in_data.coef_value),
        .raddr (t_reg),
        .rdata (w_q)
    );

    assign mult = win_q * $signed({1'b0, w_q});

    // Round half up, then clip to the sample range.
    assign rsum    = {acc_reg[ACC_W-1], acc_reg} + ROUND_K;
    assign rnd     = rsum[ACC_W:WEIGHT_BITS];
    assign sat     = !((&rnd[R_W-1:SAMPLE_BITS-1]) || !(|rnd[R_W-1:SAMPLE_BITS-1]));
    assign clamped = rnd[R_W-1] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                                : {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

    always_comb
    begin
        out_data_next.smoothed    = sat ? $signed(clamped) : $signed(rnd[SAMPLE_BITS-1:0]);
        out_data_next.last_of_row = row_mode_reg && (c_reg == '0);
        out_data_next.saturated   = sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= HALF_RESET;
            wp_reg         <= '0;
            pos_reg        <= '0;
            fill_reg       <= '0;
            c_reg          <= '0;
            row_mode_reg   <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                half_width_reg <= cfg_data;
            end
            if (win_we)
            begin
                wp_reg       <= wp_next;
                pos_reg      <= pos_next;
                fill_reg     <= fill_next;
                c_reg        <= c_next;
                row_mode_reg <= in_data.row_end;
            end
            if (cmd.load_out)
            begin
                if (c_reg == '0)
                begin
                    if (row_mode_reg)
                    begin
                        pos_reg  <= '0;
                        fill_reg <= '0;
                    end
                end
                else
                begin
                    c_reg <= c_reg - HALF_W'(1);
                end
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            t_reg     <= '0;
            d_reg     <= $signed((ADDR_W + 2)'(ch));
            raddr_reg <= start_x[ADDR_W-1:0];
            acc_reg   <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                t_reg     <= t_reg + ADDR_W'(1);
                d_reg     <= d_reg - $signed((ADDR_W + 2)'(1));
                raddr_reg <= raddr_next;
            end
            if (v2_reg)
            begin
                acc_reg <= acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
        end
        tag1_reg <= d_ok;
        prod_reg <= tag1_reg ? mult : '0;
        if (cmd.load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // A sample inside an open row yields at most one output, so only a row
    // end walks c down to zero over several outputs.
    always_comb
    begin
        st.is_sample  = (in_data.kind == KIND_SAMPLE);
        st.emit       = in_data.row_end || (int'(pos_next) > int'(h));
        st.last_tap   = (t_reg == ADDR_W'({h, 1'b0}));
        st.drain_done = !v1_reg;
        st.pipe_empty = !v1_reg && !v2_reg;
        st.out_free   = !out_valid_reg || !out_stall;
        st.last_out   = (c_reg == '0) || !row_mode_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### verif/ksf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksf_checker: result predictor and comparator for the smoothing filter
// Watches the input, configuration and output channels, keeps its own copy of
// the delay line, kernel, row position and half width, and compares every
// smoothed bin with the oldest predicted one.
// ----------------------------------------------------------------------------
module ksf_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  ksf_pkg::in_item_t                 in_data,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  ksf_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [ksf_pkg::HALF_CFG_BITS-1:0] cfg_data,
    output int                                mismatches,
    output int                                outstanding
);

    import ksf_pkg::*;

    logic signed [SAMPLE_BITS-1:0] window [MAX_TAPS];
    logic [WEIGHT_BITS-1:0]        weights [MAX_TAPS];
    logic [POS_BITS-1:0]           row_pos;
    logic [HALF_CFG_BITS-1:0]      half_cfg;
    out_item_t                     predicted_bins [$];
    int                            fails;

    // Weighted sum centred `centre` samples before the newest one.
    function automatic out_item_t smooth_bin(int centre, int h, logic last);
        longint    acc;
        longint    lim_hi;
        longint    lim_lo;
        int        d;
        out_item_t r;
        acc = 0;
        for (int t = 0; t <= 2 * h; t++)
        begin
            d = centre + h - t;
            if (d >= 0 && d < MAX_TAPS)
                acc += longint'(window[d]) * longint'(weights[t]);
        end
        acc    = (acc + (longint'(1) <<< (WEIGHT_BITS - 1))) >>> WEIGHT_BITS;
        lim_hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lim_lo = -(longint'(1) <<< (SAMPLE_BITS - 1));
        r.last_of_row = last;
        r.saturated   = 1'b0;
        if (acc > lim_hi)
        begin
            acc         = lim_hi;
            r.saturated = 1'b1;
        end
        else if (acc < lim_lo)
        begin
            acc         = lim_lo;
            r.saturated = 1'b1;
        end
        r.smoothed = acc[SAMPLE_BITS-1:0];
        return r;
    endfunction

    task automatic take_item(in_item_t it);
        int h;
        int cnt;
        h = (half_cfg < HALF_LIM) ? int'(half_cfg) : HALF_LIM;
        if (it.kind == KIND_COEF)
        begin
            if (it.coef_index < MAX_TAPS)
                weights[it.coef_index] = it.coef_value;
        end
        else
        begin
            for (int i = MAX_TAPS - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = it.sample;
            if (row_pos < POS_MAX)
                row_pos++;
            if (it.row_end)
            begin
                cnt = (row_pos < h + 1) ? int'(row_pos) : h + 1;
                for (int c = cnt; c > 0; c--)
                    predicted_bins = {predicted_bins, smooth_bin(c - 1, h, c == 1)};
                for (int i = 0; i < MAX_TAPS; i++)
                    window[i] = '0;
                row_pos = '0;
            end
            else if (row_pos > h)
                predicted_bins = {predicted_bins, smooth_bin(h, h, 1'b0)};
        end
    endtask

    task automatic check_bin(out_item_t got);
        out_item_t want;
        if (predicted_bins.size() == 0)
        begin
            fails++;
            $display("%0t: unexpected smoothed bin %0d last %0b sat %0b",
                     $time, got.smoothed, got.last_of_row, got.saturated);
            return;
        end
        want = predicted_bins.pop_front();
        if (got.smoothed !== want.smoothed)
        begin
            fails++;
            $display("%0t: smoothed expected %0d actual %0d",
                     $time, want.smoothed, got.smoothed);
        end
        if (got.last_of_row !== want.last_of_row)
        begin
            fails++;
            $display("%0t: last_of_row expected %0b actual %0b",
                     $time, want.last_of_row, got.last_of_row);
        end
        if (got.saturated !== want.saturated)
        begin
            fails++;
            $display("%0t: saturated expected %0b actual %0b",
                     $time, want.saturated, got.saturated);
        end
    endtask

    // Results leave before the input of the same edge is folded in, since no
    // item can produce a result at the edge where it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
                window[i] = '0;
            row_pos  = '0;
            half_cfg = HALF_RESET;
            predicted_bins.delete();
            fails = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_bin(out_data);
            if (cfg_valid && cfg_ready)
                half_cfg = cfg_data;
            if (in_valid && !in_stall)
                take_item(in_data);
            mismatches  <= fails;
            outstanding <= predicted_bins.size();
        end
    end

endmodule

### verif/kernel_smoothing_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_smoothing_filter_core_tb: stimulus and verdict for the smoothing filter
// Loads kernels, streams histogram rows under several half widths with random
// gaps on both channels and one long output hold-off, and leaves prediction
// and comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module kernel_smoothing_filter_core_tb;
    import ksf_pkg::*;

    // Upper bound of the random gap that sender and receiver insert per transfer.
    localparam int GAP_MAX        = 11;
    // Idle time added once the checker expects no more results, before
    // the next phase may start.
    localparam int SETTLE_CYCLES  = 80;
    localparam int BINS_PER_PHASE = 10;
    // Row streamed under the long output hold-off; a few samples are enough
    // to fill the block and leave the sender waiting.
    localparam int LONG_ROW       = 10;
    // Output hold-off that lets the block fill up and stall its input.
    localparam int LONG_HOLD      = 400;

    localparam logic signed [SAMPLE_BITS-1:0] BIN_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] BIN_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [WEIGHT_BITS-1:0]        W_FULL  = '1;
    localparam logic [WEIGHT_BITS-1:0]        W_ZERO  = '0;
    localparam logic [COEF_IDX_BITS-1:0]      IDX_OOR = '1;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    in_item_t                 in_data;
    logic                     out_valid;
    logic                     out_stall;
    out_item_t                out_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [HALF_CFG_BITS-1:0] cfg_data;
    int                       mismatches;
    int                       outstanding;

    // Phase controls shared by the sender and the receiver. Both are changed
    // only at a rising edge with nonblocking assignments.
    bit calm         = 1'b0;
    bit pressure_req = 1'b0;

    kernel_smoothing_filter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ksf_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // A hung block ends the run here.
    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sample item; the coefficient fields are ignored by the block, so they
    // carry random bits.
    function automatic in_item_t bin_item(logic signed [SAMPLE_BITS-1:0] v, logic last);
        in_item_t it;
        it.kind       = KIND_SAMPLE;
        it.sample     = v;
        it.row_end    = last;
        it.coef_index = COEF_IDX_BITS'($urandom);
        it.coef_value = WEIGHT_BITS'($urandom);
        return it;
    endfunction

    // Kernel write; sample and row_end are ignored, so they are random too.
    function automatic in_item_t tap_item(logic [COEF_IDX_BITS-1:0] idx,
                                          logic [WEIGHT_BITS-1:0] w);
        in_item_t it;
        it.kind       = KIND_COEF;
        it.sample     = SAMPLE_BITS'($urandom);
        it.row_end    = 1'($urandom);
        it.coef_index = idx;
        it.coef_value = w;
        return it;
    endfunction

    // Bin values: the rails, small values near zero, and the full range.
    function automatic logic signed [SAMPLE_BITS-1:0] draw_bin();
        int v;
        case ($urandom_range(0, 5))
            0: v = int'(BIN_MAX);
            1: v = int'(BIN_MIN);
            2: v = int'($urandom_range(0, 8191)) - 4096;
            default: v = int'($urandom);
        endcase
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Weights scaled so that a kernel of 2h+1 taps sums to about one, with
    // an occasional full-range weight that drives the sum into clipping.
    function automatic logic [WEIGHT_BITS-1:0] draw_weight(int h);
        int cap;
        cap = 131072 / (2 * h + 1);
        if (cap > 65535)
            cap = 65535;
        if ($urandom_range(0, 7) == 0)
            return WEIGHT_BITS'($urandom);
        return WEIGHT_BITS'($urandom_range(0, cap));
    endfunction

    // One input transfer: an optional idle gap, then valid held with a fixed
    // payload until the block stops stalling.
    task automatic send_item(in_item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_row(int len, bit close);
        for (int i = 0; i < len; i++)
            send_item(bin_item(draw_bin(), close && i == len - 1));
    endtask

    // Rows of random length, BINS_PER_PHASE samples in all. The last row is
    // sometimes left open, so the next half width takes over in the middle
    // of a row.
    task automatic send_rows(int hw);
        int sent;
        int len;
        bit close;
        sent = 0;
        while (sent < BINS_PER_PHASE)
        begin
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(hw + 1, hw + 12);
            else
                len = $urandom_range(1, hw + 2);
            if (len > BINS_PER_PHASE - sent)
                len = BINS_PER_PHASE - sent;
            sent += len;
            close = (sent < BINS_PER_PHASE) || ($urandom_range(0, 2) != 0);
            send_row(len, close);
        end
    endtask

    // Rewrite taps 0..2h with fresh weights for half width h.
    task automatic load_kernel(int h);
        for (int t = 0; t <= 2 * h; t++)
            send_item(tap_item(COEF_IDX_BITS'(t), draw_weight(h)));
    endtask

    // The outstanding count from the checker is registered, so the first look
    // waits for the edge after the last input transfer. The settle time then
    // follows before the task returns.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Half width writes happen only on an idle block.
    task automatic write_half(int h);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= HALF_CFG_BITS'(h);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Receiver. Each result waits a random gap of up to GAP_MAX, counted
    // only while valid is offered, before it is taken. Once asked, it holds
    // the output off for LONG_HOLD in one piece while the sender offers samples.
    initial
    begin : result_sink
        int wait_left;
        int hold_left;
        bit hold_used;
        wait_left = 0;
        hold_left = 0;
        hold_used = 1'b0;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                wait_left = calm ? 0 : $urandom_range(0, GAP_MAX);
            if (pressure_req && !hold_used)
            begin
                hold_left = LONG_HOLD;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (wait_left > 0)
            begin
                out_stall <= 1'b1;
                if (out_valid)
                    wait_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The kernel RAM comes up undefined, so every tap is written before
        // any sample can read it. The reset half width of 17 is in force.
        for (int t = 0; t < MAX_TAPS; t++)
            send_item(tap_item(COEF_IDX_BITS'(t), draw_weight(17)));

        // An index past the last tap must be dropped, whatever its weight.
        send_item(tap_item(IDX_OOR, W_FULL));
        // Row shorter than the half width: nothing comes out until its last
        // sample, which then flushes all three outputs at once.
        send_item(bin_item(BIN_MAX, 1'b0));
        send_item(bin_item(BIN_MIN, 1'b0));
        send_item(bin_item('0, 1'b1));

        // Three-tap kernel at full weight: a row at the positive rail clips
        // high, one at the negative rail clips low.
        write_half(1);
        send_item(tap_item(COEF_IDX_BITS'(0), W_FULL));
        send_item(tap_item(COEF_IDX_BITS'(1), W_FULL));
        send_item(tap_item(COEF_IDX_BITS'(2), W_FULL));
        send_row(0, 1'b0);
        send_item(bin_item(BIN_MAX, 1'b0));
        send_item(bin_item(BIN_MAX, 1'b0));
        send_item(bin_item(BIN_MAX, 1'b1));
        send_item(bin_item(BIN_MIN, 1'b0));
        send_item(bin_item(BIN_MIN, 1'b1));
        // A zero centre tap, a single-sample row, and a row longer than the
        // half width so that outputs come out while the row is still open.
        send_item(tap_item(COEF_IDX_BITS'(1), W_ZERO));
        send_item(bin_item(draw_bin(), 1'b1));
        send_row(5, 1'b1);

        // Half width 0 with a single-tap kernel keeps every result cheap.
        // The receiver's hold-off lands while this row is streaming.
        write_half(0);
        load_kernel(0);
        pressure_req <= 1'b1;
        send_row(LONG_ROW, 1'b1);
        send_rows(0);

        // Widest kernel, with no gaps on either side. Every tap already holds
        // a weight from the writes above, so the kernel is used as it stands.
        write_half(HALF_LIM);
        calm <= 1'b1;
        send_rows(HALF_LIM);

        wait_idle();
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
sv/ksf_pkg.sv
sv/ksf_ram.sv
sv/ksf_ctrl.sv
sv/ksf_datapath.sv
sv/kernel_smoothing_filter_core.sv
verif/ksf_checker.sv
verif/kernel_smoothing_filter_core_tb.sv
